>>> hw/rtl/tvkv_pkg.sv
package tvkv_pkg;

  localparam int KEY_W   = 4;
  localparam int STAMP_W = 32;
  localparam int WORD_W  = 32;

  typedef enum logic {
    CMD_SET = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

endpackage

>>> hw/rtl/tvkv_if.sv
interface tvkv_req_if import tvkv_pkg::*;;
  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [KEY_W-1:0]   key_index;
  logic [STAMP_W-1:0] stamp;
  logic [WORD_W-1:0]  data_word;

  modport source (output valid, output cmd, output key_index, output stamp,
                  output data_word, input ready);
  modport sink   (input valid, input cmd, input key_index, input stamp,
                  input data_word, output ready);
endinterface

interface tvkv_rsp_if import tvkv_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [WORD_W-1:0] read_word;
  logic              overflow;

  modport source (output valid, output hit, output read_word, output overflow,
                  input ready);
  modport sink   (input valid, input hit, input read_word, input overflow,
                  output ready);
endinterface

>>> hw/rtl/tvkv_ram.sv
module tvkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/time_versioned_key_value_store_unit.sv
// Channel | Dir | Payload                              | Transfer
// req     | in  | cmd, key_index, stamp, data_word     | valid & ready
// rsp     | out | hit, read_word, overflow             | valid & ready
//
// A set passes through S_SET to S_DONE, which loads its result into the output register; ready
// returns then. A get goes from S_START to S_DONE for an empty list, via S_FIRST below the first
// stamp, else via S_FIRST, the S_SEARCH steps and, on a hit, S_WORD; each search step waits on
// the registered read of the stamp memory. The next request can transfer once S_IDLE is back.
// Reset (synchronous) clears all list lengths at once; the version memories need no clearing.
// A new request is taken while an earlier result still waits in the output register; a
// stalled output only holds the sequencer at its final step.
module time_versioned_key_value_store_unit import tvkv_pkg::*; #(
  parameter int KEY_COUNT  = 16,
  parameter int LIST_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  tvkv_req_if.sink   req,
  tvkv_rsp_if.source rsp
);

  localparam int ENTRIES  = KEY_COUNT * LIST_DEPTH;
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int IDX_W    = $clog2(LIST_DEPTH);
  localparam int LEN_W    = $clog2(LIST_DEPTH + 1);
  localparam int KEY_SPAN = 2 ** KEY_W;
  localparam int LEN_KEYS = (KEY_COUNT < KEY_SPAN) ? KEY_COUNT : KEY_SPAN;
  localparam int LKEY_W   = (LEN_KEYS > 1) ? $clog2(LEN_KEYS) : 1;

  localparam logic [KEY_W:0]      KEY_LIMIT = (KEY_W + 1)'(LEN_KEYS);
  localparam logic [ADDR_W-1:0]   STRIDE    = ADDR_W'(LIST_DEPTH);
  localparam logic [LEN_W-1:0]    FULL_LEN  = LEN_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_START,
    S_FIRST,
    S_SEARCH,
    S_WORD,
    S_DONE
  } state_t;

  state_t             state;
  logic [KEY_W-1:0]   key_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [WORD_W-1:0]  word_r;
  logic [ADDR_W-1:0]  base;
  logic [LEN_W-1:0]   lo;
  logic [LEN_W-1:0]   hi;
  logic [IDX_W-1:0]   mid;
  logic               res_hit;
  logic [WORD_W-1:0]  res_word;
  logic               res_ovf;
  logic               out_valid;
  logic               out_hit;
  logic [WORD_W-1:0]  out_word;
  logic               out_ovf;
  logic [LEN_W-1:0]   lengths [LEN_KEYS];

  logic               key_ok;
  logic [LEN_W-1:0]   len_cur;
  logic               is_full;
  logic [STAMP_W-1:0] stamp_rd;
  logic [WORD_W-1:0]  word_rd;
  logic               gt;
  logic [LEN_W-1:0]   lo_n;
  logic [LEN_W-1:0]   hi_n;
  logic [LEN_W:0]     sum_n;
  logic [IDX_W-1:0]   mid_n;
  logic [IDX_W-1:0]   last_n;
  logic [IDX_W-1:0]   idx;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;

  assign key_ok  = {1'b0, key_r} < KEY_LIMIT;
  assign len_cur = key_ok ? lengths[key_r[LKEY_W-1:0]] : '0;
  assign is_full = (len_cur == FULL_LEN);

  // One step of the upper-bound search, driven by the stamp read at mid.
  assign gt     = stamp_rd > stamp_r;
  assign lo_n   = gt ? lo : (LEN_W'(mid) + LEN_W'(1));
  assign hi_n   = gt ? LEN_W'(mid) : hi;
  assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n  = IDX_W'(sum_n >> 1);
  assign last_n = IDX_W'(hi_n - LEN_W'(1));

  always_comb begin
    idx    = '0;
    mem_we = 1'b0;
    unique case (state)
      S_SET: begin
        idx    = IDX_W'(len_cur);
        mem_we = key_ok && !is_full;
      end
      S_FIRST:  idx = IDX_W'(len_cur >> 1);
      S_SEARCH: idx = (lo_n < hi_n) ? mid_n : last_n;
      default:  idx = '0;
    endcase
  end

  assign mem_addr = base + ADDR_W'(idx);

  tvkv_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (stamp_r),
    .rdata (stamp_rd)
  );

  tvkv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_word_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (word_r),
    .rdata (word_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < LEN_KEYS; i++) begin
        lengths[i] <= '0;
      end
    end else begin
      // In S_DONE the output register is either reloaded or still blocked.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key_r   <= req.key_index;
            stamp_r <= req.stamp;
            word_r  <= req.data_word;
            base    <= ADDR_W'(req.key_index) * STRIDE;
            state   <= (req.cmd == CMD_SET) ? S_SET : S_START;
          end
        end
        S_SET: begin
          res_hit  <= 1'b0;
          res_word <= '0;
          res_ovf  <= !key_ok || is_full;
          if (key_ok && !is_full) begin
            lengths[key_r[LKEY_W-1:0]] <= len_cur + LEN_W'(1);
          end
          state <= S_DONE;
        end
        S_START: begin
          res_hit  <= 1'b0;
          res_word <= '0;
          res_ovf  <= 1'b0;
          if (!key_ok || len_cur == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          // The memory now shows the first stamp of the list.
          if (stamp_r < stamp_rd) begin
            state <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= len_cur;
            mid   <= IDX_W'(len_cur >> 1);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          lo <= lo_n;
          hi <= hi_n;
          if (lo_n < hi_n) begin
            mid <= mid_n;
          end else if (hi_n == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_WORD;
          end
        end
        S_WORD: begin
          res_hit  <= 1'b1;
          res_word <= word_rd;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_hit   <= res_hit;
            out_word  <= res_word;
            out_ovf   <= res_ovf;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.read_word = out_word;
  assign rsp.overflow  = out_ovf;

endmodule

>>> hw/rtl/tvkv_checker.sv
module tvkv_checker import tvkv_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_hit,
  input logic [WORD_W-1:0] rsp_read_word,
  input logic              rsp_overflow
);

  logic [1:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Requests taken whose results have not yet been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_xfer} - {1'b0, rsp_xfer};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  a_rsp_owed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result offered with no request outstanding");

  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests outstanding");

  a_hit_no_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> !rsp_overflow)
    else $error("hit and overflow flagged together");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_read_word == '0)
    else $error("nonzero word without a hit");

endmodule

bind time_versioned_key_value_store_unit tvkv_checker u_tvkv_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_read_word (rsp.read_word),
  .rsp_overflow  (rsp.overflow)
);

>>> tb/tvkv_version_monitor.sv
`timescale 1ns / 100ps

module tvkv_version_monitor import tvkv_pkg::*; #(
  parameter int KEY_COUNT  = 16,
  parameter int LIST_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  tvkv_req_if        req,
  tvkv_rsp_if        rsp,
  output int         error_count,
  output int         pending
);

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] read_word;
    logic              overflow;
  } lookup_result_t;

  logic [STAMP_W-1:0] stamp_mem [KEY_COUNT][LIST_DEPTH];
  logic [WORD_W-1:0]  word_mem  [KEY_COUNT][LIST_DEPTH];
  int                 list_len  [KEY_COUNT];
  lookup_result_t     expected_q[$];
  int                 fail_total = 0;
  int                 pending_count = 0;

  assign error_count = fail_total;
  assign pending     = pending_count;

  // Applies one request to the shadow version lists and returns its result.
  function automatic lookup_result_t apply_request(cmd_t op, int key,
                                                   logic [STAMP_W-1:0] st,
                                                   logic [WORD_W-1:0] wd);
    lookup_result_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    if (op == CMD_SET) begin
      if (key >= KEY_COUNT || list_len[key] >= LIST_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        stamp_mem[key][list_len[key]] = st;
        word_mem[key][list_len[key]]  = wd;
        list_len[key]++;
      end
    end else if (key < KEY_COUNT && list_len[key] != 0 && st >= stamp_mem[key][0]) begin
      // Upper-bound search; the list need not be sorted, the search runs regardless.
      lo = 0;
      hi = list_len[key];
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (stamp_mem[key][mid] > st) hi = mid;
        else lo = mid + 1;
      end
      if (hi != 0) begin
        r.hit       = 1'b1;
        r.read_word = word_mem[key][hi-1];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      for (int k = 0; k < KEY_COUNT; k++) list_len[k] = 0;
      expected_q.delete();
    end else begin
      // The result side goes first: a result can never belong to a request
      // accepted at the same edge.
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got = {rsp.hit, rsp.read_word, rsp.overflow};
        if (expected_q.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: unexpected result hit=%b read_word=%h overflow=%b",
                     $realtime, got.hit, got.read_word, got.overflow);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit || got.read_word !== want.read_word ||
              got.overflow !== want.overflow) begin
            if (fail_total < 10)
              $display("%0t: mismatch hit %b/%b read_word %h/%h overflow %b/%b (exp/got)",
                       $realtime, want.hit, got.hit, want.read_word, got.read_word,
                       want.overflow, got.overflow);
            fail_total++;
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        expected_q.insert(expected_q.size(),
                          apply_request(req.cmd, int'(req.key_index), req.stamp,
                                        req.data_word));
    end
    pending_count = expected_q.size();
  end

endmodule

>>> tb/time_versioned_key_value_store_unit_tb.sv
`timescale 1ns / 100ps

module time_versioned_key_value_store_unit_tb import tvkv_pkg::*;;

  localparam int KEY_COUNT    = 16;
  localparam int LIST_DEPTH   = 64;
  localparam int ITEM_TARGET  = 1850;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   error_count;
  int   pending;
  int   items_sent = 0;
  int   holds_asked = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  // Stamps the block has actually stored per key, used to aim lookups.
  logic [STAMP_W-1:0] sent_stamps[KEY_COUNT][$];

  always #5 clk = ~clk;

  tvkv_req_if req_ch();
  tvkv_rsp_if rsp_ch();

  time_versioned_key_value_store_unit #(
    .KEY_COUNT (KEY_COUNT),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  tvkv_version_monitor #(
    .KEY_COUNT (KEY_COUNT),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_monitor (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .error_count(error_count),
    .pending    (pending)
  );

  // Picks a lookup stamp near what the key holds: exact hits, neighbors,
  // below the first entry, the top of the range, or anything at all.
  function automatic logic [STAMP_W-1:0] lookup_stamp(int key);
    int n;
    logic [STAMP_W-1:0] s;
    n = sent_stamps[key].size();
    if (n == 0) return $urandom;
    s = sent_stamps[key][$urandom_range(n - 1, 0)];
    case ($urandom_range(7, 0))
      0: return sent_stamps[key][0] - 1;
      1: return s + 1;
      2: return s - 1;
      3: return '1;
      4: return $urandom;
      default: return s;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(cmd_t op, int key, logic [STAMP_W-1:0] st, logic [WORD_W-1:0] wd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= op;
    req_ch.key_index <= key[KEY_W-1:0];
    req_ch.stamp     <= st;
    req_ch.data_word <= wd;
    if (op == CMD_SET && key < KEY_COUNT && sent_stamps[key].size() < LIST_DEPTH)
      sent_stamps[key].insert(sent_stamps[key].size(), st);
    items_sent++;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Receiver: changing stall patterns, plus one long hold-off when asked.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    int phase;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    phase = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3, 0);
          mode_left = $urandom_range(256, 32);
        end
        mode_left--;
        phase++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(3, 0) != 0);
          2: rsp_ch.ready <= ($urandom_range(3, 0) == 0);
          default: rsp_ch.ready <= ((phase % 11) > 3);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("time_versioned_key_value_store_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int key;
    logic [STAMP_W-1:0] st;
    logic [STAMP_W-1:0] last;
    bit hold_done;
    bit pause_done;
    hold_done = 0;
    pause_done = 0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_SET;
    req_ch.key_index = '0;
    req_ch.stamp     = '0;
    req_ch.data_word = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list, below the first stamp, exact and in-between lookups.
    send(CMD_GET, 0, 32'd5, 32'hDEAD_BEEF);
    send(CMD_SET, 0, 32'd100, 32'h1111_1111);
    send(CMD_GET, 0, 32'd99, $urandom);
    send(CMD_GET, 0, 32'd100, $urandom);
    send(CMD_SET, 0, 32'd200, 32'h2222_2222);
    send(CMD_GET, 0, 32'd150, $urandom);
    send(CMD_GET, 0, 32'd200, $urandom);
    send(CMD_GET, 0, 32'hFFFF_FFFF, $urandom);
    // Field extremes on the last key.
    send(CMD_SET, 15, 32'h0, 32'h0);
    send(CMD_GET, 15, 32'h0, 32'hFFFF_FFFF);
    send(CMD_SET, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_GET, 15, 32'hFFFF_FFFF, 32'h0);
    send(CMD_GET, 15, 32'hFFFF_FFFE, $urandom);
    // Stamps stored out of order.
    send(CMD_SET, 3, 32'd50, 32'hAAAA_0001);
    send(CMD_SET, 3, 32'd10, 32'hAAAA_0002);
    send(CMD_SET, 3, 32'd30, 32'hAAAA_0003);
    send(CMD_GET, 3, 32'd40, $urandom);
    send(CMD_GET, 3, 32'd10, $urandom);
    send(CMD_GET, 3, 32'd50, $urandom);
    send(CMD_GET, 3, 32'hFFFF_FFFF, $urandom);

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 600) begin
        hold_done = 1;
        holds_asked++;
      end
      if (!pause_done && items_sent >= 1200) begin
        // Let every outstanding result drain before going on.
        pause_done = 1;
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
      end
      kind = (items_sent < 30) ? 16 : $urandom_range(19, 0);
      key = $urandom_range(1, 0) ? $urandom_range(KEY_COUNT - 1, 0) : $urandom_range(5, 0);
      if (kind <= 9) begin
        // Stamps rising, then lookups against them.
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          last = sent_stamps[key].size() ? sent_stamps[key][$] : $urandom_range(5000, 0);
          st = last + (($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(1000, 1));
          send(CMD_SET, key, st, $urandom);
        end
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send(CMD_GET, key, lookup_stamp(key), $urandom);
      end else if (kind <= 12) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
          key = $urandom_range(KEY_COUNT - 1, 0);
          send(CMD_GET, key, lookup_stamp(key), $urandom);
        end
      end else if (kind <= 15) begin
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) send(CMD_SET, key, $urandom, $urandom);
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) send(CMD_GET, key, lookup_stamp(key), $urandom);
      end else if (kind == 16) begin
        // Top up the fullest list, then push past its end.
        for (int k = 0; k < KEY_COUNT; k++)
          if (sent_stamps[k].size() > sent_stamps[key].size()) key = k;
        while (sent_stamps[key].size() < LIST_DEPTH) begin
          last = sent_stamps[key].size() ? sent_stamps[key][$] : '0;
          send(CMD_SET, key, last + $urandom_range(500, 1), $urandom);
        end
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) send(CMD_SET, key, $urandom, $urandom);
        n = $urandom_range(4, 2);
        for (int i = 0; i < n; i++) send(CMD_GET, key, lookup_stamp(key), $urandom);
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
          send(cmd_t'($urandom_range(1, 0)), $urandom_range(KEY_COUNT - 1, 0),
               $urandom, $urandom);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("time_versioned_key_value_store_unit_tb: clean");
    end else begin
      $display("time_versioned_key_value_store_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tvkv_pkg.sv
hw/rtl/tvkv_if.sv
hw/rtl/tvkv_ram.sv
hw/rtl/time_versioned_key_value_store_unit.sv
hw/rtl/tvkv_checker.sv
tb/tvkv_version_monitor.sv
tb/time_versioned_key_value_store_unit_tb.sv
